// ===== rtl/mse_pkg.sv =====
package mse_pkg;

  // Width of the value fields on both channels.
  localparam int ITEM_W = 32;

endpackage

// ===== rtl/mse_in_if.sv =====
interface mse_in_if;

  logic                        valid;
  logic                        ready;
  logic [mse_pkg::ITEM_W-1:0]  item_value;
  logic                        last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);

endinterface

// ===== rtl/mse_out_if.sv =====
interface mse_out_if;

  logic                        valid;
  logic                        ready;
  logic [mse_pkg::ITEM_W-1:0]  sorted_value;
  logic                        final_output;

  modport source (output valid, output sorted_value, output final_output, input ready);
  modport sink   (input valid, input sorted_value, input final_output, output ready);

endinterface

// ===== rtl/mse_ram.sv =====
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/merge_sort_engine.sv =====
// Loading: one beat per cycle, no result until the beat flagged last.
// Sorting: ceil(log2 N) merge passes; each pass sets up every run pair in S_SEG and merges it
// in S_MERGE through the shared comparator, ping-ponging between two RAMs.
// Output: a prime state (S_OUT_RD) reads the first item, then one sorted beat per cycle while the sink is ready.
// Reset clears the sequencer, item count and output valid; the RAMs are not cleared.
module merge_sort_engine #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mse_in_if.sink    in_i,
  mse_out_if.source out_o
);

  localparam int ItemW = mse_pkg::ITEM_W;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IW    = CNT_W + 2;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SEG    = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_OUT_RD = 3'd3;
  localparam logic [2:0] S_OUT_LD = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [IW-1:0]    w_q, w_d;
  logic [IW-1:0]    lo_q, lo_d;
  logic [IW-1:0]    mid_q, mid_d;
  logic [IW-1:0]    hi_q, hi_d;
  logic [IW-1:0]    i_q, i_d;
  logic [IW-1:0]    j_q, j_d;
  logic [IW-1:0]    k_q, k_d;
  logic [AW-1:0]    r_q, r_d;
  logic             src_q, src_d;
  logic             out_valid_q, out_valid_d;
  logic [ItemW-1:0] out_value_q;
  logic             out_final_q;

  logic                  in_fire;
  logic                  out_fire;
  logic                  has_room;
  logic [VALUE_BITS-1:0] in_val;
  logic [IW-1:0]         n_ext;
  logic [IW-1:0]         mid_c, hi_c, lo_nxt, w_nxt;
  logic [IW-1:0]         seg_mid_raw, seg_hi_raw;

  logic signed [VALUE_BITS-1:0] rd_a, rd_b;
  logic [VALUE_BITS-1:0]        rd0_a, rd0_b, rd1_a, rd1_b;
  logic                         take_a;
  logic [VALUE_BITS-1:0]        merge_val;
  logic                         merge_we;
  logic                         load_we;
  logic                         out_load;
  logic                         last_out;
  logic                         out_phase;

  logic [AW-1:0]         raddr_a, raddr_b;
  logic                  we0, we1;
  logic [AW-1:0]         waddr0, waddr1;
  logic [VALUE_BITS-1:0] wdata0;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign has_room = (count_q < CNT_W'(MAX_ITEMS));
  assign in_val   = VALUE_BITS'($signed(in_i.item_value));
  assign n_ext    = IW'(n_q);

  // Run boundaries of the current pair, clamped to the list end.
  assign seg_mid_raw = lo_q + w_q - IW'(1);
  assign seg_hi_raw  = lo_q + (w_q << 1) - IW'(1);
  assign mid_c       = (seg_mid_raw < n_ext) ? seg_mid_raw : n_ext - IW'(1);
  assign hi_c        = (seg_hi_raw < n_ext) ? seg_hi_raw : n_ext - IW'(1);
  assign lo_nxt      = lo_q + (w_q << 1);
  assign w_nxt       = w_q << 1;

  // Read data of the current source RAM.
  assign rd_a = src_q ? rd1_a : rd0_a;
  assign rd_b = src_q ? rd1_b : rd0_b;

  // Shared comparator: while both runs hold items, the lower run wins only when strictly smaller.
  assign take_a    = (i_q <= mid_q) && ((j_q > hi_q) || (rd_a < rd_b));
  assign merge_val = take_a ? rd_a : rd_b;
  assign merge_we  = (state_q == S_MERGE);
  assign load_we   = (state_q == S_LOAD) && in_fire && has_room;

  assign out_load  = (state_q == S_OUT_LD) && (!out_valid_q || out_o.ready);
  assign last_out  = (CNT_W'(r_q) == n_q - CNT_W'(1));
  assign out_phase = (state_q == S_OUT_RD) || (state_q == S_OUT_LD);

  // Sequencer for loading, merge passes and read-out.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    r_d     = r_q;
    src_d   = src_q;
    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            count_d = count_q + CNT_W'(1);
          end
          if (in_i.last_item) begin
            n_d   = has_room ? count_q + CNT_W'(1) : count_q;
            src_d = 1'b0;
            w_d   = IW'(1);
            lo_d  = '0;
            r_d   = '0;
            state_d = (n_d == CNT_W'(1)) ? S_OUT_RD : S_SEG;
          end
        end
      end
      S_SEG: begin
        mid_d   = mid_c;
        hi_d    = hi_c;
        i_d     = lo_q;
        j_d     = mid_c + IW'(1);
        k_d     = lo_q;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        if (take_a) begin
          i_d = i_q + IW'(1);
        end else begin
          j_d = j_q + IW'(1);
        end
        k_d = k_q + IW'(1);
        if (k_q == hi_q) begin
          if (lo_nxt >= n_ext) begin
            src_d = ~src_q;
            w_d   = w_nxt;
            lo_d  = '0;
            r_d   = '0;
            state_d = (w_nxt >= n_ext) ? S_OUT_RD : S_SEG;
          end else begin
            lo_d    = lo_nxt;
            state_d = S_SEG;
          end
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (out_load) begin
          if (last_out) begin
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            r_d = r_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Output register: loaded from the RAM, cleared when its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      n_q         <= '0;
      w_q         <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      r_q         <= '0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      w_q         <= w_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      r_q         <= r_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, sign-extended back to the channel width.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= ItemW'(rd_a);
      out_final_q <= last_out;
    end
  end

  // RAM ports: both RAMs share the read addresses; the merge writes the other one.
  assign raddr_a = out_phase ? r_d : i_d[AW-1:0];
  assign raddr_b = j_d[AW-1:0];
  assign we0     = load_we || (merge_we && src_q);
  assign we1     = merge_we && !src_q;
  assign waddr0  = (state_q == S_LOAD) ? count_q[AW-1:0] : k_q[AW-1:0];
  assign waddr1  = k_q[AW-1:0];
  assign wdata0  = (state_q == S_LOAD) ? in_val : merge_val;

  mse_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_list_ram (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (waddr0),
    .wdata_i  (wdata0),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd0_a),
    .rdata_b_o(rd0_b)
  );

  mse_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_scratch_ram (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (waddr1),
    .wdata_i  (merge_val),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd1_a),
    .rdata_b_o(rd1_b)
  );

  assign in_i.ready         = (state_q == S_LOAD);
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.final_output = out_final_q;

endmodule

// ===== rtl/mse_checker.sv =====
module mse_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped before it was taken");

  // A beat that does not close the list leaves the block ready to load.
  a_load_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)
    else $error("block stopped loading after a beat that was not last");

  // The closing beat starts the sort (or, for a single item, the read-out), so loading stops.
  a_sort_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("block still loading after the closing beat");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.last_item),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready)
);
